>>> hw/rtl/rsvp_message_object_validator_unit_assert.svh
// Assertion macros shared by the validator RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef RSVP_MESSAGE_OBJECT_VALIDATOR_UNIT_ASSERT_SVH
`define RSVP_MESSAGE_OBJECT_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RMOV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RMOV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rmov_pkg.sv
`timescale 1ns / 1ps

package rmov_pkg;

	// RSVP message types
	localparam logic [2:0] MSG_NONE      = 3'd0;
	localparam logic [2:0] MSG_PATH      = 3'd1;
	localparam logic [2:0] MSG_RESV      = 3'd2;
	localparam logic [2:0] MSG_PATHERR   = 3'd3;
	localparam logic [2:0] MSG_RESVERR   = 3'd4;
	localparam logic [2:0] MSG_PATHTEAR  = 3'd5;
	localparam logic [2:0] MSG_RESVTEAR  = 3'd6;
	localparam logic [2:0] MSG_RESVCONF  = 3'd7;

	// Object class numbers
	localparam logic [7:0] CLS_NULL        = 8'd0;
	localparam logic [7:0] CLS_SESSION     = 8'd1;
	localparam logic [7:0] CLS_HOP         = 8'd3;
	localparam logic [7:0] CLS_INTEGRITY   = 8'd4;
	localparam logic [7:0] CLS_TIMEVALUES  = 8'd5;
	localparam logic [7:0] CLS_ERRORSPEC   = 8'd6;
	localparam logic [7:0] CLS_SCOPE       = 8'd7;
	localparam logic [7:0] CLS_STYLE       = 8'd8;
	localparam logic [7:0] CLS_FLOWSPEC    = 8'd9;
	localparam logic [7:0] CLS_FILTERSPEC  = 8'd10;
	localparam logic [7:0] CLS_SNDTEMPLATE = 8'd11;
	localparam logic [7:0] CLS_SNDTSPEC    = 8'd12;
	localparam logic [7:0] CLS_POLICY      = 8'd14;
	localparam logic [7:0] CLS_RESVCONFIRM = 8'd15;

	// Error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_DUP         = 3'd1;
	localparam logic [2:0] ERR_INVALID     = 3'd2;
	localparam logic [2:0] ERR_MISSING     = 3'd3;
	localparam logic [2:0] ERR_NOFLOW      = 3'd4;
	localparam logic [2:0] ERR_BEFORESTYLE = 3'd5;
	localparam logic [2:0] ERR_NODESC      = 3'd6;

	// ResvErr descriptor position
	localparam logic [1:0] TAIL_WANT_FLOW   = 2'd0;
	localparam logic [1:0] TAIL_WANT_FILTER = 2'd1;
	localparam logic [1:0] TAIL_DONE        = 2'd2;

	localparam int NEED_DEPTH = 6;

	typedef logic [15:0] class_mask_t;
	typedef logic [3:0]  class_idx_t;
	typedef class_idx_t  need_row_t [NEED_DEPTH];

	typedef struct packed {
		logic       found;
		class_idx_t cls;
	} rmov_miss_t;

	function automatic class_mask_t cbit(logic [7:0] c);
		class_mask_t m;
		m = '0;
		m[c[3:0]] = 1'b1;
		return m;
	endfunction

	// Classes that may appear at most once ahead of the descriptor list.
	function automatic class_mask_t allowed_once(logic [2:0] t);
		class_mask_t m;
		unique case (t)
			MSG_PATH:     m = cbit(CLS_SESSION) | cbit(CLS_HOP) | cbit(CLS_TIMEVALUES)
			                  | cbit(CLS_SNDTEMPLATE) | cbit(CLS_SNDTSPEC);
			MSG_RESV:     m = cbit(CLS_SESSION) | cbit(CLS_HOP) | cbit(CLS_TIMEVALUES)
			                  | cbit(CLS_RESVCONFIRM) | cbit(CLS_SCOPE);
			MSG_PATHERR:  m = cbit(CLS_SESSION) | cbit(CLS_ERRORSPEC) | cbit(CLS_SNDTEMPLATE)
			                  | cbit(CLS_SNDTSPEC);
			MSG_RESVERR:  m = cbit(CLS_SESSION) | cbit(CLS_HOP) | cbit(CLS_ERRORSPEC)
			                  | cbit(CLS_SCOPE);
			MSG_PATHTEAR: m = cbit(CLS_SESSION) | cbit(CLS_HOP) | cbit(CLS_SNDTEMPLATE)
			                  | cbit(CLS_SNDTSPEC);
			MSG_RESVTEAR: m = cbit(CLS_SESSION) | cbit(CLS_HOP) | cbit(CLS_SCOPE);
			MSG_RESVCONF: m = cbit(CLS_SESSION) | cbit(CLS_ERRORSPEC) | cbit(CLS_RESVCONFIRM);
			default:      m = '0;
		endcase
		return m;
	endfunction

	// Mandatory classes in check order; zero ends the list.
	function automatic need_row_t need_list(logic [2:0] t);
		need_row_t r;
		r = '{default: '0};
		unique case (t)
			MSG_PATH: begin
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_HOP[3:0]; r[2] = CLS_TIMEVALUES[3:0];
				r[3] = CLS_SNDTEMPLATE[3:0]; r[4] = CLS_SNDTSPEC[3:0];
			end
			MSG_RESV: begin
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_HOP[3:0]; r[2] = CLS_TIMEVALUES[3:0];
				r[3] = CLS_STYLE[3:0];
			end
			MSG_PATHERR: begin
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_ERRORSPEC[3:0];
				r[2] = CLS_SNDTEMPLATE[3:0]; r[3] = CLS_SNDTSPEC[3:0];
			end
			MSG_RESVERR: begin
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_HOP[3:0]; r[2] = CLS_ERRORSPEC[3:0];
				r[3] = CLS_STYLE[3:0]; r[4] = CLS_FLOWSPEC[3:0]; r[5] = CLS_FILTERSPEC[3:0];
			end
			MSG_PATHTEAR: begin
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_HOP[3:0]; r[2] = CLS_SNDTEMPLATE[3:0];
			end
			MSG_RESVTEAR: begin
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_HOP[3:0]; r[2] = CLS_STYLE[3:0];
			end
			MSG_RESVCONF: begin
				// ResvConfirm is checked ahead of Style
				r[0] = CLS_SESSION[3:0]; r[1] = CLS_ERRORSPEC[3:0];
				r[2] = CLS_RESVCONFIRM[3:0]; r[3] = CLS_STYLE[3:0];
			end
			default: r = '{default: '0};
		endcase
		return r;
	endfunction

	function automatic rmov_miss_t first_missing(logic [2:0] t, class_mask_t seen);
		need_row_t  r;
		rmov_miss_t res;
		logic       stop;
		r    = need_list(t);
		res  = '0;
		stop = 1'b0;
		for (int i = 0; i < NEED_DEPTH; i++) begin
			if (!stop) begin
				if (r[i] == '0) begin
					stop = 1'b1;
				end else if (!seen[r[i]]) begin
					res.found = 1'b1;
					res.cls   = r[i];
					stop      = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/rsvp_message_object_validator_unit.sv
`timescale 1ns / 1ps

// RSVP message object validator. Feed the object headers of one RSVP message, one
// transaction per object: msg_type and the class number in tdata, the first-object mark in
// tuser and the last-object mark in tlast. Each object is checked for order and
// multiplicity against the RFC 2205 rules of its message type (Path through
// ResvConf); the first error is latched and the rest of the message is ignored.
// On the last object one verdict transaction comes out: valid_res, error_code and
// the class that caused the error. Objects that are not last give no output. A
// leading Integrity object is skipped; a first mark in mid message restarts.
// Throughput is one object per clock while no last object stalls: the whole
// per-object check is a mask and flag update between the input register and the
// state/result registers. An object passes the input register, then its verdict the
// output register. The input register keeps taking objects while a verdict waits in
// the output register; only a second last-object stalls until the pending verdict is taken.

module rsvp_message_object_validator_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [2:0] msg_type, [10:3] object class, [15:11] zero
	input  logic        s_axis_tuser,  // [0] first_object
	input  logic        s_axis_tlast,  // last_object

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] valid_res, [3:1] error_code,
	                                   // [11:4] error_class, [15:12] zero
);

	import rmov_pkg::*;

	// input register
	logic        valid_s1;
	logic [2:0]  type_s1;
	logic [7:0]  class_s1;
	logic        first_s1;
	logic        last_s1;

	// message state
	logic [2:0]  type_q;
	class_mask_t mask_q;
	logic        phase_q;      // inside flow-descriptor list
	logic        flow_q;       // FlowSpec held for following FilterSpec
	logic        desc_q;       // at least one descriptor completed
	logic [1:0]  tail_q;       // ResvErr descriptor position
	logic [2:0]  err_q;
	logic [7:0]  ecls_q;

	// output register
	logic        out_valid_q;
	logic        res_ok_q;
	logic [2:0]  res_code_q;
	logic [7:0]  res_cls_q;

	logic        adv;

	// A last object needs the output register free (or draining this cycle).
	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			type_s1  <= s_axis_tdata[2:0];
			class_s1 <= s_axis_tdata[10:3];
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	// ---------------------------------------------------------------
	// Per-object check
	// ---------------------------------------------------------------
	logic [2:0]  t;
	class_mask_t b_mask, n_mask;
	logic        b_phase, n_phase;
	logic        b_flow, n_flow;
	logic        b_desc, n_desc;
	logic [1:0]  b_tail, n_tail;
	logic [2:0]  b_err, n_err, f_err;
	logic [7:0]  b_cls, n_cls, f_cls;
	logic        proc;
	logic        c_small;
	logic        has_desc;
	class_mask_t once_m;
	rmov_miss_t  miss;

	always_comb begin
		// a first mark starts from cleared state
		if (first_s1) begin
			t       = type_s1;
			b_mask  = '0;
			b_phase = 1'b0;
			b_flow  = 1'b0;
			b_desc  = 1'b0;
			b_tail  = TAIL_WANT_FLOW;
			b_err   = ERR_NONE;
			b_cls   = '0;
		end else begin
			t       = type_q;
			b_mask  = mask_q;
			b_phase = phase_q;
			b_flow  = flow_q;
			b_desc  = desc_q;
			b_tail  = tail_q;
			b_err   = err_q;
			b_cls   = ecls_q;
		end

		n_mask  = b_mask;
		n_phase = b_phase;
		n_flow  = b_flow;
		n_desc  = b_desc;
		n_tail  = b_tail;
		n_err   = b_err;
		n_cls   = b_cls;

		c_small  = (class_s1[7:4] == 4'd0);
		has_desc = (t == MSG_RESV) || (t == MSG_RESVERR) || (t == MSG_RESVTEAR)
		        || (t == MSG_RESVCONF);
		once_m   = allowed_once(t);
		proc     = !(first_s1 && class_s1 == CLS_INTEGRITY) && (b_err == ERR_NONE);

		// no error is latched when proc is set, so any failure here is the first
		if (proc && !(class_s1 == CLS_NULL && t != MSG_NONE)) begin
			if (b_phase) begin
				if (t == MSG_RESVERR) begin
					// strict Style, FlowSpec, FilterSpec order
					priority case (b_tail)
						TAIL_WANT_FLOW: begin
							if (class_s1 == CLS_FLOWSPEC) begin
								n_mask = b_mask | cbit(CLS_FLOWSPEC);
								n_tail = TAIL_WANT_FILTER;
							end else begin
								n_err = (class_s1 == CLS_FILTERSPEC) ? ERR_NOFLOW : ERR_INVALID;
								n_cls = class_s1;
							end
						end
						TAIL_WANT_FILTER: begin
							if (class_s1 == CLS_FILTERSPEC) begin
								n_mask = b_mask | cbit(CLS_FILTERSPEC);
								n_tail = TAIL_DONE;
							end else begin
								n_err = (class_s1 == CLS_FLOWSPEC) ? ERR_DUP : ERR_INVALID;
								n_cls = class_s1;
							end
						end
						default: begin
							n_err = (class_s1 == CLS_FLOWSPEC || class_s1 == CLS_FILTERSPEC)
							      ? ERR_DUP : ERR_INVALID;
							n_cls = class_s1;
						end
					endcase
				end else if (class_s1 == CLS_FLOWSPEC) begin
					// ResvTear ignores FlowSpec in its descriptor list
					if (t != MSG_RESVTEAR) n_flow = 1'b1;
				end else if (class_s1 == CLS_FILTERSPEC) begin
					if (t != MSG_RESVTEAR && !b_flow) begin
						n_err = ERR_NOFLOW;
						n_cls = class_s1;
					end else begin
						n_desc = 1'b1;
					end
				end else begin
					n_err = ERR_INVALID;
					n_cls = class_s1;
				end
			end else if (c_small && once_m[class_s1[3:0]]) begin
				if (b_mask[class_s1[3:0]]) begin
					n_err = ERR_DUP;
					n_cls = class_s1;
				end else begin
					n_mask = b_mask | cbit(class_s1);
				end
			end else if (class_s1 == CLS_POLICY && (t == MSG_PATH || t == MSG_RESV
			             || t == MSG_PATHERR || t == MSG_RESVERR)) begin
				// policy data may repeat freely
			end else if (class_s1 == CLS_STYLE && has_desc) begin
				n_mask  = b_mask | cbit(CLS_STYLE);
				n_phase = 1'b1;
			end else if (t == MSG_RESVCONF
			             && (class_s1 == CLS_FLOWSPEC || class_s1 == CLS_FILTERSPEC)) begin
				n_err = ERR_BEFORESTYLE;
				n_cls = class_s1;
			end else begin
				n_err = ERR_INVALID;
				n_cls = class_s1;
			end
		end

		// end-of-message checks
		miss  = first_missing(t, n_mask);
		f_err = n_err;
		f_cls = n_cls;
		if (n_err == ERR_NONE) begin
			priority if (t == MSG_NONE) begin
				f_err = ERR_MISSING;
				f_cls = '0;
			end else if (miss.found) begin
				f_err = ERR_MISSING;
				f_cls = {4'd0, miss.cls};
			end else if (t == MSG_RESVCONF && !n_flow) begin
				f_err = ERR_NODESC;
				f_cls = '0;
			end else if ((t == MSG_RESV || t == MSG_RESVTEAR || t == MSG_RESVCONF)
			             && !n_desc) begin
				f_err = ERR_NODESC;
				f_cls = '0;
			end else begin
				f_err = ERR_NONE;
				f_cls = '0;
			end
		end
	end

	// state registers: cleared after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= MSG_NONE;
			mask_q  <= '0;
			phase_q <= 1'b0;
			flow_q  <= 1'b0;
			desc_q  <= 1'b0;
			tail_q  <= TAIL_WANT_FLOW;
			err_q   <= ERR_NONE;
			ecls_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				type_q  <= MSG_NONE;
				mask_q  <= '0;
				phase_q <= 1'b0;
				flow_q  <= 1'b0;
				desc_q  <= 1'b0;
				tail_q  <= TAIL_WANT_FLOW;
				err_q   <= ERR_NONE;
				ecls_q  <= '0;
			end else begin
				type_q  <= t;
				mask_q  <= n_mask;
				phase_q <= n_phase;
				flow_q  <= n_flow;
				desc_q  <= n_desc;
				tail_q  <= n_tail;
				err_q   <= n_err;
				ecls_q  <= n_cls;
			end
		end
	end

	// verdict output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_ok_q   <= (f_err == ERR_NONE);
			res_code_q <= f_err;
			res_cls_q  <= f_cls;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, res_cls_q, res_code_q, res_ok_q};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
`include "rsvp_message_object_validator_unit_assert.svh"

	`RMOV_ASSERT_NEXT(a_clear_after_verdict, adv && last_s1,
		err_q == ERR_NONE && mask_q == '0 && !phase_q && type_q == MSG_NONE,
		"message state not cleared after verdict")
	`RMOV_ASSERT_NEXT(a_error_sticky, adv && !last_s1 && !first_s1 && err_q != ERR_NONE,
		err_q == $past(err_q) && ecls_q == $past(ecls_q),
		"latched error changed in mid message")
	`RMOV_ASSERT_NOW(a_phase_needs_style, phase_q, mask_q[CLS_STYLE[3:0]],
		"descriptor phase without Style seen")
	`RMOV_ASSERT_NOW(a_tail_range, 1'b1, tail_q != 2'd3,
		"ResvErr descriptor position out of range")
	`RMOV_ASSERT_NOW(a_ok_clean, m_axis_tvalid && m_axis_tdata[0],
		m_axis_tdata[3:1] == ERR_NONE && m_axis_tdata[11:4] == 8'd0,
		"passing verdict carries an error code or class")

endmodule

>>> bench/rsvp_object_verdict_checker.sv
`timescale 1ns / 1ps

module rsvp_object_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [2:0] msg_type, [10:3] object class, [15:11] zero
	input  logic        s_axis_tuser,  // [0] first_object
	input  logic        s_axis_tlast,  // last_object

	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // [0] valid_res, [3:1] error_code,
	                                   // [11:4] error_class, [15:12] zero

	output int          mismatches,
	output int          pending
);
	import rmov_pkg::*;

	typedef struct packed {
		logic       ok;
		logic [2:0] code;
		logic [7:0] cls;
	} verdict_t;

	verdict_t    verdicts[$];
	int          bad;

	// per-message validation state
	logic [2:0]  msg_kind;
	logic [15:0] seen;
	logic        in_desc;
	logic        flow_held;
	logic        desc_found;
	logic [1:0]  tail_pos;
	logic [2:0]  fault_code;
	logic [7:0]  fault_cls;

	function automatic void clear_message();
		msg_kind   = MSG_NONE;
		seen       = '0;
		in_desc    = 1'b0;
		flow_held  = 1'b0;
		desc_found = 1'b0;
		tail_pos   = TAIL_WANT_FLOW;
		fault_code = ERR_NONE;
		fault_cls  = '0;
	endfunction

	// first fault wins
	function automatic void note_fault(logic [2:0] code, logic [7:0] c);
		if (fault_code == ERR_NONE) begin
			fault_code = code;
			fault_cls  = c;
		end
	endfunction

	function automatic logic [15:0] single_classes(logic [2:0] t);
		logic [15:0] m;
		case (t)
			MSG_PATH:     m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_HOP)
			                | (16'd1 << CLS_TIMEVALUES) | (16'd1 << CLS_SNDTEMPLATE)
			                | (16'd1 << CLS_SNDTSPEC);
			MSG_RESV:     m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_HOP)
			                | (16'd1 << CLS_TIMEVALUES) | (16'd1 << CLS_RESVCONFIRM)
			                | (16'd1 << CLS_SCOPE);
			MSG_PATHERR:  m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_ERRORSPEC)
			                | (16'd1 << CLS_SNDTEMPLATE) | (16'd1 << CLS_SNDTSPEC);
			MSG_RESVERR:  m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_HOP)
			                | (16'd1 << CLS_ERRORSPEC) | (16'd1 << CLS_SCOPE);
			MSG_PATHTEAR: m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_HOP)
			                | (16'd1 << CLS_SNDTEMPLATE) | (16'd1 << CLS_SNDTSPEC);
			MSG_RESVTEAR: m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_HOP)
			                | (16'd1 << CLS_SCOPE);
			MSG_RESVCONF: m = (16'd1 << CLS_SESSION) | (16'd1 << CLS_ERRORSPEC)
			                | (16'd1 << CLS_RESVCONFIRM);
			default:      m = '0;
		endcase
		return m;
	endfunction

	function automatic void screen_descriptor(logic [2:0] t, logic [7:0] c);
		if (t == MSG_RESVERR) begin
			// strict Style, FlowSpec, FilterSpec tail
			case (tail_pos)
				TAIL_WANT_FLOW: begin
					if (c == CLS_FLOWSPEC) begin
						seen[CLS_FLOWSPEC[3:0]] = 1'b1;
						tail_pos = TAIL_WANT_FILTER;
					end else begin
						note_fault((c == CLS_FILTERSPEC) ? ERR_NOFLOW : ERR_INVALID, c);
					end
				end
				TAIL_WANT_FILTER: begin
					if (c == CLS_FILTERSPEC) begin
						seen[CLS_FILTERSPEC[3:0]] = 1'b1;
						tail_pos = TAIL_DONE;
					end else begin
						note_fault((c == CLS_FLOWSPEC) ? ERR_DUP : ERR_INVALID, c);
					end
				end
				default: begin
					note_fault((c == CLS_FLOWSPEC || c == CLS_FILTERSPEC) ? ERR_DUP : ERR_INVALID,
						c);
				end
			endcase
		end else if (c == CLS_FLOWSPEC) begin
			if (t != MSG_RESVTEAR)
				flow_held = 1'b1;
		end else if (c == CLS_FILTERSPEC) begin
			if (t != MSG_RESVTEAR && !flow_held)
				note_fault(ERR_NOFLOW, c);
			else
				desc_found = 1'b1;
		end else begin
			note_fault(ERR_INVALID, c);
		end
	endfunction

	function automatic void screen_object(logic [2:0] t, logic [7:0] c);
		logic [15:0] once_set;
		logic        has_list;
		once_set = single_classes(t);
		has_list = (t == MSG_RESV) || (t == MSG_RESVERR) || (t == MSG_RESVTEAR)
			|| (t == MSG_RESVCONF);
		if (c == CLS_NULL && t != MSG_NONE)
			return;
		if (in_desc) begin
			screen_descriptor(t, c);
		end else if (c < 8'd16 && once_set[c[3:0]]) begin
			if (seen[c[3:0]])
				note_fault(ERR_DUP, c);
			else
				seen[c[3:0]] = 1'b1;
		end else if (c == CLS_POLICY && t >= MSG_PATH && t <= MSG_RESVERR) begin
			// policy data may repeat
		end else if (c == CLS_STYLE && has_list) begin
			seen[CLS_STYLE[3:0]] = 1'b1;
			in_desc = 1'b1;
		end else if (t == MSG_RESVCONF && (c == CLS_FLOWSPEC || c == CLS_FILTERSPEC)) begin
			note_fault(ERR_BEFORESTYLE, c);
		end else begin
			note_fault(ERR_INVALID, c);
		end
	endfunction

	function automatic void closing_checks(logic [2:0] t);
		logic [7:0] needed [6];
		if (fault_code != ERR_NONE)
			return;
		if (t == MSG_NONE) begin
			note_fault(ERR_MISSING, CLS_NULL);
			return;
		end
		needed = '{default: CLS_NULL};
		case (t)
			MSG_PATH:     needed = '{CLS_SESSION, CLS_HOP, CLS_TIMEVALUES, CLS_SNDTEMPLATE,
			                         CLS_SNDTSPEC, CLS_NULL};
			MSG_RESV:     needed = '{CLS_SESSION, CLS_HOP, CLS_TIMEVALUES, CLS_STYLE,
			                         CLS_NULL, CLS_NULL};
			MSG_PATHERR:  needed = '{CLS_SESSION, CLS_ERRORSPEC, CLS_SNDTEMPLATE, CLS_SNDTSPEC,
			                         CLS_NULL, CLS_NULL};
			MSG_RESVERR:  needed = '{CLS_SESSION, CLS_HOP, CLS_ERRORSPEC, CLS_STYLE,
			                         CLS_FLOWSPEC, CLS_FILTERSPEC};
			MSG_PATHTEAR: needed = '{CLS_SESSION, CLS_HOP, CLS_SNDTEMPLATE, CLS_NULL,
			                         CLS_NULL, CLS_NULL};
			MSG_RESVTEAR: needed = '{CLS_SESSION, CLS_HOP, CLS_STYLE, CLS_NULL,
			                         CLS_NULL, CLS_NULL};
			default:      needed = '{CLS_SESSION, CLS_ERRORSPEC, CLS_RESVCONFIRM, CLS_STYLE,
			                         CLS_NULL, CLS_NULL};
		endcase
		// lists end at the first zero, later entries are zero too
		for (int n = 0; n < 6; n++)
			if (needed[n] != CLS_NULL && !seen[needed[n][3:0]])
				note_fault(ERR_MISSING, needed[n]);
		if (t == MSG_RESVCONF && !flow_held)
			note_fault(ERR_NODESC, CLS_NULL);
		if ((t == MSG_RESV || t == MSG_RESVTEAR || t == MSG_RESVCONF) && !desc_found)
			note_fault(ERR_NODESC, CLS_NULL);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			bad++;
		end
	endfunction

	always @(posedge clk) begin
		verdict_t   want;
		logic [7:0] c;
		if (!arst_n) begin
			clear_message();
			verdicts.delete();
			bad = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				c = s_axis_tdata[10:3];
				if (s_axis_tuser) begin
					clear_message();
					msg_kind = s_axis_tdata[2:0];
				end
				// a leading Integrity object is skipped
				if (!(s_axis_tuser && c == CLS_INTEGRITY) && fault_code == ERR_NONE)
					screen_object(msg_kind, c);
				if (s_axis_tlast) begin
					closing_checks(msg_kind);
					want.ok   = (fault_code == ERR_NONE);
					want.code = fault_code;
					want.cls  = (fault_code == ERR_NONE) ? 8'd0 : fault_cls;
					verdicts = {verdicts, want};
					clear_message();
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdicts.size() == 0) begin
					$error("verdict 0x%04h with no message closed", m_axis_tdata);
					bad++;
				end else begin
					want = verdicts.pop_front();
					check_field("valid_res", 8'(want.ok), 8'(m_axis_tdata[0]));
					check_field("error_code", 8'(want.code), 8'(m_axis_tdata[3:1]));
					check_field("error_class", want.cls, m_axis_tdata[11:4]);
					check_field("tdata pad", 8'd0, 8'(m_axis_tdata[15:12]));
				end
			end
		end
		mismatches <= bad;
		pending    <= verdicts.size();
	end

endmodule

>>> bench/tb_rsvp_message_object_validator_unit.sv
`timescale 1ns / 1ps

// Stimulus side: builds RSVP object sequences and feeds them to the validator, one
// transaction per object. The checker beside the DUT predicts every verdict.

module tb_rsvp_message_object_validator_unit;
	import rmov_pkg::*;

	localparam int RANDOM_ITEMS = 1100;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;    // [2:0] msg_type, [10:3] object class, [15:11] zero
	logic        s_axis_tuser  = 1'b0;  // [0] first_object
	logic        s_axis_tlast  = 1'b0;  // last_object
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // [0] valid_res, [3:1] error_code,
	                                    // [11:4] error_class, [15:12] zero

	int          mismatches;
	int          pending;
	int          items_sent;
	int          burst_left;
	logic [7:0]  msg_objs[$];           // class numbers of the message being built

	// receiver stall pattern state
	int          stall_mode = 0;
	int          mode_left  = 0;
	int          cycle      = 0;

	initial forever #5 clk = ~clk;

	rsvp_message_object_validator_unit i_dut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata
	);

	rsvp_object_verdict_checker i_checker (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.mismatches,
		.pending
	);

	// Receiver: switches at random between four stall patterns. Mode 0 is
	// a clean stretch with no back-pressure at all.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 200);
		end
		mode_left--;
		cycle++;
		case (stall_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= 1'($urandom_range(0, 1));
			2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((cycle % 5) < 2);  // periodic pattern, mostly stalled
		endcase
	end

	// One object transaction. The sender runs in bursts; between bursts tvalid
	// drops for a random gap. Long bursts give stretches with no idling.
	task automatic send_object(logic [2:0] t, logic [7:0] c, logic first, logic last);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		// msg_type only matters with the first mark; otherwise it is noise
		s_axis_tdata  <= {5'd0, c, first ? t : 3'($urandom_range(0, 7))};
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Sends msg_objs; open/close control the first and last marks so that headless
	// and unterminated messages come from the same path.
	task automatic send_message(logic [2:0] t, logic open, logic close);
		for (int i = 0; i < msg_objs.size(); i++)
			send_object(t, msg_objs[i], open && (i == 0), close && (i == msg_objs.size() - 1));
	endtask

	// Builds a mostly well-formed object list for message type t: once-only header
	// objects in random order, then Style and the flow descriptors. A few objects
	// go missing and seven in twelve messages get a corruption on top.
	task automatic compose_message(logic [2:0] t);
		logic [7:0] pool[$];
		logic [7:0] tmp;
		int         j;
		int         k;
		int         n;
		msg_objs.delete();
		pool.delete();
		case (t)
			MSG_PATH:     pool = '{CLS_SESSION, CLS_HOP, CLS_TIMEVALUES, CLS_SNDTEMPLATE,
			                       CLS_SNDTSPEC};
			MSG_RESV:     pool = '{CLS_SESSION, CLS_HOP, CLS_TIMEVALUES, CLS_RESVCONFIRM,
			                       CLS_SCOPE};
			MSG_PATHERR:  pool = '{CLS_SESSION, CLS_ERRORSPEC, CLS_SNDTEMPLATE, CLS_SNDTSPEC};
			MSG_RESVERR:  pool = '{CLS_SESSION, CLS_HOP, CLS_ERRORSPEC, CLS_SCOPE};
			MSG_PATHTEAR: pool = '{CLS_SESSION, CLS_HOP, CLS_SNDTEMPLATE, CLS_SNDTSPEC};
			MSG_RESVTEAR: pool = '{CLS_SESSION, CLS_HOP, CLS_SCOPE};
			MSG_RESVCONF: pool = '{CLS_SESSION, CLS_ERRORSPEC, CLS_RESVCONFIRM};
			default:      pool.delete();
		endcase
		// policy data is legal and repeatable for Path through ResvErr
		if (t >= MSG_PATH && t <= MSG_RESVERR && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) pool = {pool, CLS_POLICY};
		for (j = pool.size() - 1; j > 0; j--) begin
			k       = $urandom_range(0, j);
			tmp     = pool[j];
			pool[j] = pool[k];
			pool[k] = tmp;
		end
		if ($urandom_range(0, 3) == 0)
			msg_objs = {msg_objs, CLS_INTEGRITY};
		foreach (pool[i])
			if ($urandom_range(0, 9) != 0)
				msg_objs = {msg_objs, pool[i]};

		if (t == MSG_RESV || t == MSG_RESVERR || t == MSG_RESVTEAR || t == MSG_RESVCONF) begin
			if ($urandom_range(0, 15) != 0)
				msg_objs = {msg_objs, CLS_STYLE};
			if (t == MSG_RESVERR) begin
				if ($urandom_range(0, 15) != 0)
					msg_objs = {msg_objs, CLS_FLOWSPEC};
				if ($urandom_range(0, 15) != 0)
					msg_objs = {msg_objs, CLS_FILTERSPEC};
			end else begin
				n = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
				repeat (n) begin
					if ((t == MSG_RESVTEAR) ? ($urandom_range(0, 2) == 0)
						: ($urandom_range(0, 7) != 0))
						msg_objs = {msg_objs, CLS_FLOWSPEC};
					repeat ($urandom_range(1, 2)) msg_objs = {msg_objs, CLS_FILTERSPEC};
				end
			end
		end

		if (msg_objs.size() == 0)
			msg_objs = {msg_objs, CLS_SESSION};
		j = $urandom_range(0, msg_objs.size() - 1);
		case ($urandom_range(0, 11))
			0: msg_objs.insert(j, 8'($urandom_range(0, 15)));
			1: msg_objs.insert(j, 8'($urandom_range(16, 255)));
			2: msg_objs.insert(j, msg_objs[j]);                   // duplicate
			3: begin                                              // swap neighbors
				if (j > 0) begin
					tmp             = msg_objs[j];
					msg_objs[j]     = msg_objs[j - 1];
					msg_objs[j - 1] = tmp;
				end
			end
			4: if (msg_objs.size() > 1) msg_objs.delete(j);
			5, 6: msg_objs.insert(j, CLS_NULL);
			default: ;
		endcase
	endtask

	initial begin
		int         pick;
		int         base;
		int         n;
		logic [2:0] kind;
		burst_left = 0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a clean Path with leading Integrity and policy data
		msg_objs = '{CLS_INTEGRITY, CLS_SESSION, CLS_HOP, CLS_TIMEVALUES, CLS_SNDTEMPLATE,
			CLS_POLICY, CLS_SNDTSPEC};
		send_message(MSG_PATH, 1'b1, 1'b1);
		// untyped single-object message with the top class number
		msg_objs = '{8'hFF};
		send_message(MSG_NONE, 1'b1, 1'b1);
		// ResvConf FlowSpec ahead of Style
		msg_objs = '{CLS_SESSION, CLS_FLOWSPEC};
		send_message(MSG_RESVCONF, 1'b1, 1'b1);
		// Null ignored, then a duplicate Session
		msg_objs = '{CLS_SESSION, CLS_NULL, CLS_SESSION};
		send_message(MSG_RESV, 1'b1, 1'b1);
		// ResvErr with a repeated FlowSpec after the full tail
		msg_objs = '{CLS_SESSION, CLS_HOP, CLS_ERRORSPEC, CLS_STYLE, CLS_FLOWSPEC,
			CLS_FILTERSPEC, CLS_FLOWSPEC};
		send_message(MSG_RESVERR, 1'b1, 1'b1);
		// headless object after a verdict: untyped message, Null is invalid there
		msg_objs = '{CLS_NULL};
		send_message(MSG_PATH, 1'b0, 1'b1);
		// ResvTear whose only descriptor is an ignored FlowSpec
		msg_objs = '{CLS_SESSION, CLS_HOP, CLS_STYLE, CLS_FLOWSPEC};
		send_message(MSG_RESVTEAR, 1'b1, 1'b1);

		base = items_sent;
		while (items_sent < base + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			kind = 3'($urandom_range(1, 7));
			compose_message(kind);
			if (pick < 78) begin
				send_message(kind, 1'b1, 1'b1);
			end else if (pick < 84) begin
				// cut short; the next first mark restarts mid message
				while (msg_objs.size() > 1 && $urandom_range(0, 1) == 0)
					void'(msg_objs.pop_back());
				send_message(kind, 1'b1, 1'b0);
			end else if (pick < 90) begin
				// no first mark: continues whatever state is left
				n = $urandom_range(1, 3);
				while (msg_objs.size() > n)
					void'(msg_objs.pop_front());
				send_message(kind, 1'b0, 1'b1);
			end else if (pick < 94) begin
				send_message(MSG_NONE, 1'b1, 1'b1);
			end else begin
				// raw noise over the full field ranges
				repeat ($urandom_range(1, 6))
					send_object(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;
		while (pending != 0) @(posedge clk);
		// leave room for anything stray
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (about 1200 objects, each with its
	// random gap and any receiver stalls, stays under 0.5 ms).
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
